>>> sv/drop_shadow_frame_filter_macros.svh
// Assertion shorthands shared by the checker.
`ifndef DROP_SHADOW_FRAME_FILTER_MACROS_SVH
`define DROP_SHADOW_FRAME_FILTER_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define DSF_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define DSF_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> sv/dsf_pkg.sv
`default_nettype none

package dsf_pkg;

  localparam int MAX_WIDTH   = 128;
  localparam int MAX_HEIGHT  = 128;
  localparam int STORE_DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int ADDR_W      = $clog2(STORE_DEPTH);
  localparam int XC_W        = $clog2(MAX_WIDTH);
  localparam int YC_W        = $clog2(MAX_HEIGHT);
  localparam int XB_W        = $clog2(MAX_WIDTH + 1);
  localparam int YB_W        = $clog2(MAX_HEIGHT + 1);
  localparam int PIX_W       = 32;

  localparam logic [7:0] CH_MAX             = 8'd255;
  localparam logic [7:0] DIM_RESET          = 8'd128;
  localparam logic [7:0] SHADOW_ALPHA_RESET = 8'd255;
  localparam logic [7:0] OFFSET_MIN_CODE    = 8'h80;
  localparam logic [6:0] OFFSET_MAG_MAX     = 7'd127;

  typedef enum logic [1:0] {
    REQ_WRITE = 2'd0,
    REQ_RUN   = 2'd1,
    REQ_READ  = 2'd2
  } req_t;

  typedef enum logic [2:0] {
    CFG_OFFSET_X     = 3'd0,
    CFG_OFFSET_Y     = 3'd1,
    CFG_IMAGE_WIDTH  = 3'd2,
    CFG_IMAGE_HEIGHT = 3'd3,
    CFG_SHADOW_RED   = 3'd4,
    CFG_SHADOW_GREEN = 3'd5,
    CFG_SHADOW_BLUE  = 3'd6,
    CFG_SHADOW_ALPHA = 3'd7
  } cfg_reg_t;

  typedef struct packed {
    logic [7:0] alpha;
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
  } pixel_t;

  typedef logic [ADDR_W-1:0] addr_t;

  typedef struct packed {
    logic  valid;
    logic  region;
    addr_t addr;
  } sweep_tag_t;

  typedef struct packed {
    logic   we;
    addr_t  addr;
    pixel_t data;
  } wr_port_t;

  function automatic addr_t pix_addr(logic [XC_W-1:0] x, logic [YC_W-1:0] y);
    return ADDR_W'(y) * ADDR_W'(MAX_WIDTH) + ADDR_W'(x);
  endfunction

  function automatic logic [7:0] div255(logic [15:0] v);
    logic [16:0] t;
    t = 17'(v) + 17'(v[15:8]) + 17'd1;
    return t[15:8];
  endfunction

  function automatic logic [15:0] clamp_dim(logic [7:0] v, logic [15:0] max_v);
    if (v == 8'd0) return 16'd1;
    if (16'(v) > max_v) return max_v;
    return 16'(v);
  endfunction

endpackage

`default_nettype wire

>>> sv/dsf_ram.sv
`default_nettype none

module dsf_ram #(
  parameter int DEPTH = 16384,
  parameter int WIDTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  output logic [WIDTH-1:0]         rdata_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_a_r;
  logic [WIDTH-1:0] rdata_b_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_a_r <= mem_r[raddr_a];
    rdata_b_r <= mem_r[raddr_b];
  end

  assign rdata_a = rdata_a_r;
  assign rdata_b = rdata_b_r;

endmodule

`default_nettype wire

>>> sv/dsf_blend.sv
`default_nettype none

module dsf_blend (
  input  logic                 clk,
  input  logic                 rst_n,
  input  dsf_pkg::sweep_tag_t  tag_in,
  input  dsf_pkg::pixel_t      self_px,
  input  dsf_pkg::pixel_t      nb_px,
  input  dsf_pkg::pixel_t      shadow,
  output dsf_pkg::wr_port_t    wr,
  output logic                 active
);

  dsf_pkg::sweep_tag_t tag0_r;

  logic                s1_valid_r, s1_valid_nxt;
  logic                s1_region_r, s1_region_nxt;
  dsf_pkg::addr_t      s1_addr_r, s1_addr_nxt;
  dsf_pkg::pixel_t     s1_self_r, s1_self_nxt;
  logic [15:0]         s1_sum_red_r, s1_sum_red_nxt;
  logic [15:0]         s1_sum_green_r, s1_sum_green_nxt;
  logic [15:0]         s1_sum_blue_r, s1_sum_blue_nxt;
  logic [15:0]         s1_sa_prod_r, s1_sa_prod_nxt;
  logic [7:0]          s1_alpha_r, s1_alpha_nxt;

  logic                s2_valid_r, s2_valid_nxt;
  logic                s2_region_r, s2_region_nxt;
  dsf_pkg::addr_t      s2_addr_r, s2_addr_nxt;
  dsf_pkg::pixel_t     s2_self_r, s2_self_nxt;
  logic [7:0]          s2_red_r, s2_red_nxt;
  logic [7:0]          s2_green_r, s2_green_nxt;
  logic [7:0]          s2_blue_r, s2_blue_nxt;
  logic [7:0]          s2_sa_r, s2_sa_nxt;
  logic [15:0]         s2_al_prod_r, s2_al_prod_nxt;

  logic [7:0]          inv_alpha;
  logic [7:0]          out_alpha;
  dsf_pkg::pixel_t     blended;

  always_comb begin
    inv_alpha        = dsf_pkg::CH_MAX - self_px.alpha;
    s1_valid_nxt     = tag0_r.valid;
    s1_region_nxt    = tag0_r.region;
    s1_addr_nxt      = tag0_r.addr;
    s1_self_nxt      = self_px;
    s1_alpha_nxt     = self_px.alpha;
    s1_sum_red_nxt   = 16'(shadow.red) * 16'(inv_alpha) + 16'(self_px.red) * 16'(self_px.alpha);
    s1_sum_green_nxt = 16'(shadow.green) * 16'(inv_alpha)
                     + 16'(self_px.green) * 16'(self_px.alpha);
    s1_sum_blue_nxt  = 16'(shadow.blue) * 16'(inv_alpha)
                     + 16'(self_px.blue) * 16'(self_px.alpha);
    s1_sa_prod_nxt   = 16'(shadow.alpha) * 16'(nb_px.alpha);

    s2_valid_nxt     = s1_valid_r;
    s2_region_nxt    = s1_region_r;
    s2_addr_nxt      = s1_addr_r;
    s2_self_nxt      = s1_self_r;
    s2_red_nxt       = dsf_pkg::div255(s1_sum_red_r);
    s2_green_nxt     = dsf_pkg::div255(s1_sum_green_r);
    s2_blue_nxt      = dsf_pkg::div255(s1_sum_blue_r);
    s2_sa_nxt        = dsf_pkg::div255(s1_sa_prod_r);
    s2_al_prod_nxt   = 16'(s1_alpha_r) * 16'(dsf_pkg::CH_MAX - s2_sa_nxt);
  end

  always_ff @(posedge clk) begin
    tag0_r.region  <= tag_in.region;
    tag0_r.addr    <= tag_in.addr;
    s1_region_r    <= s1_region_nxt;
    s1_addr_r      <= s1_addr_nxt;
    s1_self_r      <= s1_self_nxt;
    s1_sum_red_r   <= s1_sum_red_nxt;
    s1_sum_green_r <= s1_sum_green_nxt;
    s1_sum_blue_r  <= s1_sum_blue_nxt;
    s1_sa_prod_r   <= s1_sa_prod_nxt;
    s1_alpha_r     <= s1_alpha_nxt;
    s2_region_r    <= s2_region_nxt;
    s2_addr_r      <= s2_addr_nxt;
    s2_self_r      <= s2_self_nxt;
    s2_red_r       <= s2_red_nxt;
    s2_green_r     <= s2_green_nxt;
    s2_blue_r      <= s2_blue_nxt;
    s2_sa_r        <= s2_sa_nxt;
    s2_al_prod_r   <= s2_al_prod_nxt;
    if (!rst_n) begin
      tag0_r.valid <= 1'b0;
      s1_valid_r   <= 1'b0;
      s2_valid_r   <= 1'b0;
    end else begin
      tag0_r.valid <= tag_in.valid;
      s1_valid_r   <= s1_valid_nxt;
      s2_valid_r   <= s2_valid_nxt;
    end
  end

  always_comb begin
    out_alpha     = s2_sa_r + dsf_pkg::div255(s2_al_prod_r);
    blended.alpha = out_alpha;
    blended.blue  = s2_blue_r;
    blended.green = s2_green_r;
    blended.red   = s2_red_r;
    wr.we         = s2_valid_r;
    wr.addr       = s2_addr_r;
    wr.data       = s2_region_r ? blended : s2_self_r;
  end

  assign active = tag0_r.valid | s1_valid_r | s2_valid_r;

endmodule

`default_nettype wire

>>> sv/drop_shadow_frame_filter.sv
// Drop-shadow filter over a stored RGBA frame of MAX_WIDTH x MAX_HEIGHT pixels.
// Input channel (in_valid/in_stall) carries one request per transaction:
//   write pixel: stored at the accepting edge, next item accepted the next cycle
//                unless a held, stalled result keeps the input stalled.
//   read pixel:  registered in the memory, then in the output register, and shown
//                on out_valid; the input stalls until the result is in place.
//   run filter:  |offset_x| passes along x, then |offset_y| along y, each capped
//                at 127. Each pass sweeps the whole frame memory, one pixel per
//                cycle, reading the current bank and writing the other, then
//                swaps banks. The input stalls for the whole run, also when
//                both offsets are zero.
// The output holds its result while out_stall is high; a new read is not taken
// until the pending result has been taken.
// Configuration (cfg_valid/cfg_ready, always ready) sets offsets, frame size and
// shadow colour; write it only while no item is in flight.
// Reset restores configuration defaults, state, bank and handshake flags; the
// frame memories are not cleared, and a pixel must be written before it is read.
`default_nettype none

module drop_shadow_frame_filter (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [1:0] in_req_type,
  input  logic [6:0] in_pos_x,
  input  logic [6:0] in_pos_y,
  input  logic [7:0] in_red,
  input  logic [7:0] in_green,
  input  logic [7:0] in_blue,
  input  logic [7:0] in_alpha,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_red,
  output logic [7:0] out_green,
  output logic [7:0] out_blue,
  output logic [7:0] out_alpha,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [2:0] cfg_index,
  input  logic [7:0] cfg_data
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_NEXT,
    ST_SWEEP,
    ST_DRAIN
  } state_t;

  state_t                         state_r, state_nxt;
  logic                           bank_r, bank_nxt;
  logic                           rd_pend_r, rd_pend_nxt;
  logic                           rd_zero_r, rd_zero_nxt;
  logic                           out_valid_r, out_valid_nxt;
  dsf_pkg::pixel_t                out_px_r, out_px_nxt;
  logic [7:0]                     offset_x_r, offset_x_nxt;
  logic [7:0]                     offset_y_r, offset_y_nxt;
  logic [7:0]                     width_r, width_nxt;
  logic [7:0]                     height_r, height_nxt;
  dsf_pkg::pixel_t                shadow_r, shadow_nxt;
  logic [7:0]                     passes_left_r, passes_left_nxt;
  logic [6:0]                     xpass_left_r, xpass_left_nxt;
  logic                           x_pass_r, x_pass_nxt;
  logic                           xneg_r, xneg_nxt;
  logic                           yneg_r, yneg_nxt;
  logic                           x0_r, x0_nxt;
  logic                           y0_r, y0_nxt;
  logic [dsf_pkg::XB_W-1:0]       x1_r, x1_nxt;
  logic [dsf_pkg::YB_W-1:0]       y1_r, y1_nxt;
  logic [dsf_pkg::XC_W-1:0]       sx_r, sx_nxt;
  logic [dsf_pkg::YC_W-1:0]       sy_r, sy_nxt;

  logic                           in_acc;
  logic                           in_inside;
  dsf_pkg::addr_t                 in_addr;
  dsf_pkg::pixel_t                in_px;
  logic                           host_we;
  logic [6:0]                     ox_mag;
  logic [6:0]                     oy_mag;
  logic [dsf_pkg::XB_W-1:0]       w_clamp;
  logic [dsf_pkg::YB_W-1:0]       h_clamp;
  logic [dsf_pkg::XC_W-1:0]       nx;
  logic [dsf_pkg::YC_W-1:0]       ny;
  dsf_pkg::addr_t                 self_addr;
  dsf_pkg::addr_t                 nb_addr;
  logic                           region;
  logic                           sweep_last;
  dsf_pkg::sweep_tag_t            tag;
  dsf_pkg::wr_port_t              blend_wr;
  logic                           blend_active;

  logic                           ram0_we, ram1_we;
  dsf_pkg::addr_t                 ram0_waddr, ram1_waddr;
  dsf_pkg::pixel_t                ram0_wdata, ram1_wdata;
  dsf_pkg::addr_t                 rd_addr_a;
  dsf_pkg::pixel_t                ram0_qa, ram0_qb, ram1_qa, ram1_qb;
  dsf_pkg::pixel_t                cur_a, cur_b;

  assign in_stall  = (state_r != ST_IDLE) | rd_pend_r | (out_valid_r & out_stall);
  assign in_acc    = in_valid & ~in_stall;
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_red   = out_px_r.red;
  assign out_green = out_px_r.green;
  assign out_blue  = out_px_r.blue;
  assign out_alpha = out_px_r.alpha;

  always_comb begin
    in_inside = (16'(in_pos_x) < 16'(dsf_pkg::MAX_WIDTH))
              & (16'(in_pos_y) < 16'(dsf_pkg::MAX_HEIGHT));
    in_addr   = dsf_pkg::pix_addr(dsf_pkg::XC_W'(in_pos_x), dsf_pkg::YC_W'(in_pos_y));
    in_px     = {in_alpha, in_blue, in_green, in_red};
    host_we   = in_acc & (in_req_type == dsf_pkg::REQ_WRITE) & in_inside;

    if (offset_x_r[7]) begin
      ox_mag = (offset_x_r == dsf_pkg::OFFSET_MIN_CODE) ? dsf_pkg::OFFSET_MAG_MAX
                                                        : 7'(8'd0 - offset_x_r);
    end else begin
      ox_mag = offset_x_r[6:0];
    end
    if (offset_y_r[7]) begin
      oy_mag = (offset_y_r == dsf_pkg::OFFSET_MIN_CODE) ? dsf_pkg::OFFSET_MAG_MAX
                                                        : 7'(8'd0 - offset_y_r);
    end else begin
      oy_mag = offset_y_r[6:0];
    end
    w_clamp = dsf_pkg::XB_W'(dsf_pkg::clamp_dim(width_r, 16'(dsf_pkg::MAX_WIDTH)));
    h_clamp = dsf_pkg::YB_W'(dsf_pkg::clamp_dim(height_r, 16'(dsf_pkg::MAX_HEIGHT)));

    nx = xneg_r ? sx_r - dsf_pkg::XC_W'(1) : sx_r + dsf_pkg::XC_W'(1);
    ny = yneg_r ? sy_r - dsf_pkg::YC_W'(1) : sy_r + dsf_pkg::YC_W'(1);
    self_addr = dsf_pkg::pix_addr(sx_r, sy_r);
    nb_addr   = x_pass_r ? dsf_pkg::pix_addr(nx, sy_r) : dsf_pkg::pix_addr(sx_r, ny);
    region    = (dsf_pkg::XB_W'(sx_r) >= dsf_pkg::XB_W'(x0_r))
              & (dsf_pkg::XB_W'(sx_r) < x1_r)
              & (dsf_pkg::YB_W'(sy_r) >= dsf_pkg::YB_W'(y0_r))
              & (dsf_pkg::YB_W'(sy_r) < y1_r);
    sweep_last = (sx_r == dsf_pkg::XC_W'(dsf_pkg::MAX_WIDTH - 1))
               & (sy_r == dsf_pkg::YC_W'(dsf_pkg::MAX_HEIGHT - 1));

    tag.valid  = (state_r == ST_SWEEP);
    tag.region = region;
    tag.addr   = self_addr;

    rd_addr_a  = (state_r == ST_SWEEP) ? self_addr : in_addr;

    ram0_we    = bank_r ? blend_wr.we   : host_we;
    ram0_waddr = bank_r ? blend_wr.addr : in_addr;
    ram0_wdata = bank_r ? blend_wr.data : in_px;
    ram1_we    = bank_r ? host_we       : blend_wr.we;
    ram1_waddr = bank_r ? in_addr       : blend_wr.addr;
    ram1_wdata = bank_r ? in_px         : blend_wr.data;

    cur_a = bank_r ? ram1_qa : ram0_qa;
    cur_b = bank_r ? ram1_qb : ram0_qb;
  end

  dsf_ram #(
    .DEPTH (dsf_pkg::STORE_DEPTH),
    .WIDTH (dsf_pkg::PIX_W)
  ) u_ram0 (
    .clk     (clk),
    .we      (ram0_we),
    .waddr   (ram0_waddr),
    .wdata   (ram0_wdata),
    .raddr_a (rd_addr_a),
    .rdata_a (ram0_qa),
    .raddr_b (nb_addr),
    .rdata_b (ram0_qb)
  );

  dsf_ram #(
    .DEPTH (dsf_pkg::STORE_DEPTH),
    .WIDTH (dsf_pkg::PIX_W)
  ) u_ram1 (
    .clk     (clk),
    .we      (ram1_we),
    .waddr   (ram1_waddr),
    .wdata   (ram1_wdata),
    .raddr_a (rd_addr_a),
    .rdata_a (ram1_qa),
    .raddr_b (nb_addr),
    .rdata_b (ram1_qb)
  );

  dsf_blend u_blend (
    .clk     (clk),
    .rst_n   (rst_n),
    .tag_in  (tag),
    .self_px (cur_a),
    .nb_px   (cur_b),
    .shadow  (shadow_r),
    .wr      (blend_wr),
    .active  (blend_active)
  );

  always_comb begin
    state_nxt       = state_r;
    bank_nxt        = bank_r;
    rd_pend_nxt     = rd_pend_r;
    rd_zero_nxt     = rd_zero_r;
    out_valid_nxt   = out_valid_r;
    out_px_nxt      = out_px_r;
    offset_x_nxt    = offset_x_r;
    offset_y_nxt    = offset_y_r;
    width_nxt       = width_r;
    height_nxt      = height_r;
    shadow_nxt      = shadow_r;
    passes_left_nxt = passes_left_r;
    xpass_left_nxt  = xpass_left_r;
    x_pass_nxt      = x_pass_r;
    xneg_nxt        = xneg_r;
    yneg_nxt        = yneg_r;
    x0_nxt          = x0_r;
    y0_nxt          = y0_r;
    x1_nxt          = x1_r;
    y1_nxt          = y1_r;
    sx_nxt          = sx_r;
    sy_nxt          = sy_r;

    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
    if (rd_pend_r) begin
      out_valid_nxt = 1'b1;
      out_px_nxt    = rd_zero_r ? '0 : cur_a;
      rd_pend_nxt   = 1'b0;
    end

    if (cfg_valid) begin
      case (cfg_index)
        dsf_pkg::CFG_OFFSET_X:     offset_x_nxt = cfg_data;
        dsf_pkg::CFG_OFFSET_Y:     offset_y_nxt = cfg_data;
        dsf_pkg::CFG_IMAGE_WIDTH:  width_nxt = cfg_data;
        dsf_pkg::CFG_IMAGE_HEIGHT: height_nxt = cfg_data;
        dsf_pkg::CFG_SHADOW_RED:   shadow_nxt.red = cfg_data;
        dsf_pkg::CFG_SHADOW_GREEN: shadow_nxt.green = cfg_data;
        dsf_pkg::CFG_SHADOW_BLUE:  shadow_nxt.blue = cfg_data;
        dsf_pkg::CFG_SHADOW_ALPHA: shadow_nxt.alpha = cfg_data;
        default: ;
      endcase
    end

    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          case (in_req_type)
            dsf_pkg::REQ_READ: begin
              rd_pend_nxt = 1'b1;
              rd_zero_nxt = ~in_inside;
            end
            dsf_pkg::REQ_RUN: begin
              passes_left_nxt = 8'(ox_mag) + 8'(oy_mag);
              xpass_left_nxt  = ox_mag;
              xneg_nxt        = offset_x_r[7];
              yneg_nxt        = offset_y_r[7];
              x0_nxt          = offset_x_r[7];
              y0_nxt          = offset_y_r[7];
              x1_nxt          = (!offset_x_r[7] && offset_x_r != 8'd0)
                              ? w_clamp - dsf_pkg::XB_W'(1) : w_clamp;
              y1_nxt          = (!offset_y_r[7] && offset_y_r != 8'd0)
                              ? h_clamp - dsf_pkg::YB_W'(1) : h_clamp;
              state_nxt       = ST_NEXT;
            end
            default: ;
          endcase
        end
      end
      ST_NEXT: begin
        if (passes_left_r == 8'd0) begin
          state_nxt = ST_IDLE;
        end else begin
          x_pass_nxt      = (xpass_left_r != 7'd0);
          if (xpass_left_r != 7'd0) begin
            xpass_left_nxt = xpass_left_r - 7'd1;
          end
          passes_left_nxt = passes_left_r - 8'd1;
          sx_nxt          = '0;
          sy_nxt          = '0;
          state_nxt       = ST_SWEEP;
        end
      end
      ST_SWEEP: begin
        if (sx_r == dsf_pkg::XC_W'(dsf_pkg::MAX_WIDTH - 1)) begin
          sx_nxt = '0;
          sy_nxt = sy_r + dsf_pkg::YC_W'(1);
        end else begin
          sx_nxt = sx_r + dsf_pkg::XC_W'(1);
        end
        if (sweep_last) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!blend_active) begin
          bank_nxt  = ~bank_r;
          state_nxt = ST_NEXT;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    out_px_r     <= out_px_nxt;
    rd_zero_r    <= rd_zero_nxt;
    xneg_r       <= xneg_nxt;
    yneg_r       <= yneg_nxt;
    x0_r         <= x0_nxt;
    y0_r         <= y0_nxt;
    x1_r         <= x1_nxt;
    y1_r         <= y1_nxt;
    x_pass_r     <= x_pass_nxt;
    sx_r         <= sx_nxt;
    sy_r         <= sy_nxt;
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      bank_r        <= 1'b0;
      rd_pend_r     <= 1'b0;
      out_valid_r   <= 1'b0;
      offset_x_r    <= '0;
      offset_y_r    <= '0;
      width_r       <= dsf_pkg::DIM_RESET;
      height_r      <= dsf_pkg::DIM_RESET;
      shadow_r      <= '{alpha: dsf_pkg::SHADOW_ALPHA_RESET, blue: 8'd0,
                         green: 8'd0, red: 8'd0};
      passes_left_r <= '0;
      xpass_left_r  <= '0;
    end else begin
      state_r       <= state_nxt;
      bank_r        <= bank_nxt;
      rd_pend_r     <= rd_pend_nxt;
      out_valid_r   <= out_valid_nxt;
      offset_x_r    <= offset_x_nxt;
      offset_y_r    <= offset_y_nxt;
      width_r       <= width_nxt;
      height_r      <= height_nxt;
      shadow_r      <= shadow_nxt;
      passes_left_r <= passes_left_nxt;
      xpass_left_r  <= xpass_left_nxt;
    end
  end

endmodule

`default_nettype wire

>>> sv/dsf_checker.sv
`default_nettype none
`include "drop_shadow_frame_filter_macros.svh"

module dsf_checker (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       in_valid,
  input wire logic       in_stall,
  input wire logic [1:0] in_req_type,
  input wire logic [6:0] in_pos_x,
  input wire logic [6:0] in_pos_y,
  input wire logic [7:0] in_red,
  input wire logic [7:0] in_green,
  input wire logic [7:0] in_blue,
  input wire logic [7:0] in_alpha,
  input wire logic       out_valid,
  input wire logic       out_stall,
  input wire logic [7:0] out_red,
  input wire logic [7:0] out_green,
  input wire logic [7:0] out_blue,
  input wire logic [7:0] out_alpha,
  input wire logic       cfg_valid,
  input wire logic       cfg_ready,
  input wire logic [2:0] cfg_index,
  input wire logic [7:0] cfg_data
);

  logic read_acc;

  assign read_acc = rst_n & in_valid & ~in_stall & (in_req_type == dsf_pkg::REQ_READ);

  `DSF_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_red) && $stable(out_green) && $stable(out_blue) && $stable(out_alpha), "result changed while stalled")
  `DSF_ASSERT_NEXT(a_read_stall, read_acc, in_stall, "input not held off after a read")
  `DSF_ASSERT_SAME(a_read_latency, $past(rst_n) && $past(read_acc, 2), out_valid, "read result missing two cycles after acceptance")
  `DSF_ASSERT_SAME(a_result_source, $rose(out_valid), $past(read_acc, 2), "result without a read transaction")

endmodule

bind drop_shadow_frame_filter dsf_checker u_dsf_checker (.*);

`default_nettype wire
